>>> rtl/core/cle_pkg.sv
// Package: shared constants and types for the circular list engine.
`default_nettype none
package cle_pkg;
	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [3:0] {
		K_INS_HEAD = 4'd0, K_INS_TAIL = 4'd1, K_INS_AT = 4'd2,
		K_DEL_HEAD = 4'd3, K_DEL_TAIL = 4'd4, K_DEL_AT = 4'd5,
		K_SEARCH = 4'd6, K_REVERSE = 4'd7, K_DUMP_FWD = 4'd8, K_DUMP_BWD = 4'd9
	} kind_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// datapath commands issued by the sequencer
	typedef enum logic [3:0] {
		C_NONE, C_START_HEAD, C_START_TAIL, C_STEP_NEXT, C_LINK_HEAD, C_LINK_TAIL,
		C_ALLOC_MID, C_LINK_MID, C_UNLINK, C_REV_NODE, C_REV_LAST, C_DUMP_FWD, C_DUMP_BWD
	} dcmd_t;
endpackage
`default_nettype wire

>>> rtl/core/cle_if.sv
// Interfaces: request and result channels of the circular list engine.
`default_nettype none
interface cle_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [6:0]  position;
	logic signed [31:0] item_value;
	modport source (output valid, kind, position, item_value, input ready);
	modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface cle_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        found;
	logic signed [31:0] out_value;
	logic [6:0]  size_after;
	logic        last;
	modport source (output valid, status, found, out_value, size_after, last, input ready);
	modport sink   (input valid, status, found, out_value, size_after, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/circular_list_engine.sv
// Top level: circular doubly linked list engine.
// One request at a time. Index walks, searches, reversal and dumps follow one link per
// pass through a read state and a wait state on the registered node memory read;
// dumps give one result per link, and wait while the last result is still unread.
`default_nettype none
module circular_list_engine #(
	parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cle_req_if.sink   req,
	cle_rsp_if.source rsp
);
	import cle_pkg::*;
	localparam int CW = $clog2(CAPACITY + 1);

	dcmd_t cmd;
	logic [CW-1:0] cnt;
	logic val_eq;
	logic signed [31:0] dp_value;

	cle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cmd(cmd), .cnt(cnt), .val_eq(val_eq));

	cle_dp #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item_value(req.item_value),
		.cnt(cnt), .val_eq(val_eq), .out_value(dp_value));

	assign rsp.out_value = dp_value;
	assign rsp.size_after = 7'(cnt);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_value))
		else $error("result dropped under stall");
	// no request taken while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken with pending result");
endmodule
`default_nettype wire

>>> rtl/core/cle_ctrl.sv
// Controller and datapath: list sequencer and the node memories it commands.
`default_nettype none
module cle_ctrl #(
	parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cle_req_if.sink   req,
	cle_rsp_if.source rsp,
	output cle_pkg::dcmd_t cmd,
	input  wire logic [$clog2(CAPACITY + 1)-1:0] cnt,
	input  wire logic val_eq
);
	import cle_pkg::*;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_WALK_RD, S_WALK_WAIT, S_DO, S_REV_RD, S_REV_WAIT,
		S_DUMP_RD, S_DUMP_WAIT, S_SRCH_RD, S_SRCH_WAIT, S_OUT, S_DEL_RD, S_DEL_WAIT
	} state_t;

	state_t state_q;
	logic [3:0] kind_q;
	logic [CW-1:0] pos_q, idx_q;
	logic hit_q;
	logic [1:0] st_q;
	logic last_q, rvalid_q;

	logic take;
	logic end_ins, head_ins, step_end;
	logic [CW-1:0] idx_nx;

	assign take = req.valid && req.ready;
	assign idx_nx = idx_q + CW'(1);
	assign step_end = (idx_nx == cnt);
	assign end_ins = (cnt == '0) || kind_q == K_INS_HEAD || kind_q == K_INS_TAIL ||
		pos_q == '0 || pos_q == cnt;
	assign head_ins = kind_q == K_INS_HEAD || (kind_q == K_INS_AT && pos_q == '0);

	assign req.ready = (state_q == S_IDLE) && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.status = st_q;
	assign rsp.found = hit_q;
	assign rsp.last = last_q;

	// issue the datapath command for this cycle
	always_comb begin
		cmd = C_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (take)
					cmd = (req.kind == K_DEL_TAIL || req.kind == K_DUMP_BWD) ?
						C_START_TAIL : C_START_HEAD;
			end
			S_WALK_WAIT, S_SRCH_WAIT: cmd = C_STEP_NEXT;
			S_DO: begin
				if (end_ins)
					cmd = head_ins ? C_LINK_HEAD : C_LINK_TAIL;
				else
					cmd = C_ALLOC_MID;
			end
			S_DEL_WAIT: cmd = (kind_q == K_INS_AT) ? C_LINK_MID : C_UNLINK;
			S_REV_WAIT: cmd = step_end ? C_REV_LAST : C_REV_NODE;
			S_DUMP_WAIT: cmd = (kind_q == K_DUMP_FWD) ? C_DUMP_FWD : C_DUMP_BWD;
			default: cmd = C_NONE;
		endcase
	end

	// sequencer state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; rvalid_q <= 1'b0; st_q <= ST_OK; hit_q <= 1'b0;
			last_q <= 1'b0; kind_q <= '0; pos_q <= '0; idx_q <= '0;
		end else begin
			if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) begin
					kind_q <= req.kind;
					pos_q <= (32'(req.position) > CAPACITY) ? CW'(CAPACITY) :
						CW'(req.position);
					st_q <= ST_OK; hit_q <= 1'b0; last_q <= 1'b1;
					idx_q <= '0;
					priority if (req.kind == K_INS_AT && CW'(req.position) > cnt
						&& 32'(req.position) <= CAPACITY) begin
						st_q <= ST_INDEX; state_q <= S_OUT;
					end else if (req.kind == K_INS_AT && 32'(req.position) > CAPACITY) begin
						st_q <= ST_INDEX; state_q <= S_OUT;
					end else if ((req.kind == K_INS_HEAD || req.kind == K_INS_TAIL ||
						req.kind == K_INS_AT) && 32'(cnt) >= CAPACITY) begin
						st_q <= ST_FULL; state_q <= S_OUT;
					end else if (req.kind == K_DEL_AT && 32'(req.position) >= 32'(cnt)) begin
						st_q <= ST_INDEX; state_q <= S_OUT;
					end else if ((req.kind == K_DEL_HEAD || req.kind == K_DEL_TAIL ||
						req.kind == K_SEARCH || req.kind == K_REVERSE ||
						req.kind == K_DUMP_FWD || req.kind == K_DUMP_BWD) && cnt == '0) begin
						st_q <= ST_EMPTY; state_q <= S_OUT;
					end else if (req.kind == K_INS_HEAD || req.kind == K_INS_TAIL ||
						(req.kind == K_INS_AT && (req.position == '0 ||
						CW'(req.position) == cnt))) begin
						state_q <= S_DO;
					end else if (req.kind == K_INS_AT) begin
						state_q <= (req.position == 7'd1) ? S_DO : S_WALK_RD;
						idx_q <= CW'(1);
					end else if (req.kind == K_DEL_HEAD || req.kind == K_DEL_TAIL) begin
						state_q <= S_DEL_RD;
					end else if (req.kind == K_DEL_AT) begin
						state_q <= (req.position == '0) ? S_DEL_RD : S_WALK_RD;
					end else if (req.kind == K_SEARCH) begin
						state_q <= S_SRCH_RD;
					end else if (req.kind == K_REVERSE) begin
						state_q <= S_REV_RD;
					end else if (req.kind == K_DUMP_FWD || req.kind == K_DUMP_BWD) begin
						state_q <= S_DUMP_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				// walk: advance one link per read
				S_WALK_RD: state_q <= S_WALK_WAIT;
				S_WALK_WAIT: begin
					idx_q <= idx_nx;
					if (kind_q == K_INS_AT) begin
						state_q <= (idx_nx == pos_q) ? S_DO : S_WALK_RD;
					end else begin
						state_q <= (idx_nx == pos_q) ? S_DEL_RD : S_WALK_RD;
					end
				end
				// insert: end links finish here, a middle insert reads its successor
				S_DO: state_q <= end_ins ? S_OUT : S_DEL_RD;
				S_DEL_RD: state_q <= S_DEL_WAIT;
				S_DEL_WAIT: state_q <= S_OUT;
				S_SRCH_RD: state_q <= S_SRCH_WAIT;
				S_SRCH_WAIT: begin
					idx_q <= idx_nx;
					if (val_eq) begin
						hit_q <= 1'b1; state_q <= S_OUT;
					end else state_q <= step_end ? S_OUT : S_SRCH_RD;
				end
				S_REV_RD: state_q <= S_REV_WAIT;
				S_REV_WAIT: begin
					idx_q <= idx_nx;
					state_q <= step_end ? S_OUT : S_REV_RD;
				end
				S_DUMP_RD: if (!rvalid_q || rsp.ready) state_q <= S_DUMP_WAIT;
				S_DUMP_WAIT: begin
					last_q <= step_end; rvalid_q <= 1'b1;
					idx_q <= idx_nx;
					state_q <= step_end ? S_IDLE : S_DUMP_RD;
				end
				S_OUT: begin
					rvalid_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

module cle_dp #(
	parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  var cle_pkg::dcmd_t cmd,
	input  wire logic signed [31:0] item_value,
	output logic [$clog2(CAPACITY + 1)-1:0] cnt,
	output logic val_eq,
	output logic signed [31:0] out_value
);
	import cle_pkg::*;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// node memories, read data registered
	logic [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [AW-1:0] nxt_mem [CAPACITY];
	logic [AW-1:0] prv_mem [CAPACITY];
	logic [AW-1:0] free_mem [CAPACITY];
	logic [VALUE_BITS-1:0] rval_q;
	logic [AW-1:0] rnxt_q, rprv_q, rfree_q;

	logic [CW-1:0] cnt_q, fresh_q;
	logic [AW-1:0] head_q, tail_q, cur_q, slot_q;
	logic [VALUE_BITS-1:0] v_q, ov_q;

	logic [CW-1:0] freed;
	logic [CW-1:0] fidx;
	logic [AW-1:0] new_slot;
	assign freed = fresh_q - cnt_q;
	assign fidx  = freed - CW'(1);
	assign new_slot = (freed != '0) ? rfree_q : fresh_q[AW-1:0];

	assign cnt = cnt_q;
	assign val_eq = (rval_q == v_q);
	assign out_value = 32'(signed'(ov_q));

	// read the current node and the top of the freed-slot stack, write links by command
	always_ff @(posedge clk) begin
		rval_q  <= val_mem[cur_q];
		rnxt_q  <= nxt_mem[cur_q];
		rprv_q  <= prv_mem[cur_q];
		rfree_q <= free_mem[fidx[AW-1:0]];
		unique case (cmd)
			C_LINK_HEAD, C_LINK_TAIL: begin
				val_mem[new_slot] <= v_q;
				if (cnt_q == '0) begin
					nxt_mem[new_slot] <= new_slot; prv_mem[new_slot] <= new_slot;
				end else begin
					nxt_mem[new_slot] <= head_q; prv_mem[new_slot] <= tail_q;
					prv_mem[head_q] <= new_slot; nxt_mem[tail_q] <= new_slot;
				end
			end
			C_ALLOC_MID: val_mem[new_slot] <= v_q;
			// middle link: cur_q = t, rnxt_q = n
			C_LINK_MID: begin
				nxt_mem[slot_q] <= rnxt_q; prv_mem[slot_q] <= cur_q;
				prv_mem[rnxt_q] <= slot_q; nxt_mem[cur_q] <= slot_q;
			end
			C_UNLINK: begin
				free_mem[freed[AW-1:0]] <= cur_q;
				if (cnt_q > CW'(1)) begin
					nxt_mem[rprv_q] <= rnxt_q; prv_mem[rnxt_q] <= rprv_q;
				end
			end
			C_REV_NODE, C_REV_LAST: begin
				nxt_mem[cur_q] <= rprv_q; prv_mem[cur_q] <= rnxt_q;
			end
			default: ;
		endcase
	end

	// list pointers, counts and held values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; fresh_q <= '0; head_q <= '0; tail_q <= '0;
			cur_q <= '0; slot_q <= '0; v_q <= '0; ov_q <= '0;
		end else begin
			unique case (cmd)
				C_START_HEAD, C_START_TAIL: begin
					v_q <= VALUE_BITS'(64'(signed'(item_value)));
					ov_q <= '0;
					cur_q <= (cmd == C_START_TAIL) ? tail_q : head_q;
				end
				C_STEP_NEXT: cur_q <= rnxt_q;
				C_LINK_HEAD, C_LINK_TAIL: begin
					if (freed == '0) fresh_q <= fresh_q + CW'(1);
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == '0) begin
						head_q <= new_slot; tail_q <= new_slot;
					end else if (cmd == C_LINK_HEAD) head_q <= new_slot;
					else tail_q <= new_slot;
				end
				C_ALLOC_MID: begin
					if (freed == '0) fresh_q <= fresh_q + CW'(1);
					cnt_q <= cnt_q + CW'(1);
					slot_q <= new_slot;
				end
				C_UNLINK: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q <= CW'(1)) begin
						head_q <= '0; tail_q <= '0;
					end else begin
						if (cur_q == head_q) head_q <= rnxt_q;
						if (cur_q == tail_q) tail_q <= rprv_q;
					end
				end
				C_REV_NODE: cur_q <= rnxt_q;
				C_REV_LAST: begin
					cur_q <= rnxt_q; head_q <= tail_q; tail_q <= head_q;
				end
				C_DUMP_FWD: begin
					ov_q <= rval_q; cur_q <= rnxt_q;
				end
				C_DUMP_BWD: begin
					ov_q <= rval_q; cur_q <= rprv_q;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> tb/cle_tb_pkg.sv
// Package: list model, operation helpers and shared counters for the list engine bench.
package cle_tb_pkg;
	import cle_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] out_value;
		logic [6:0]         size_after;
		logic               last;
	} rsp_t;

	localparam int POOL = CAPACITY_DEF;

	// Model state: an ordered array of values stands in for the linked pool
	int   list_vals[$];
	rsp_t expected_rsps[$];
	int   fail_count = 0;

	function automatic void push_rsp(logic [1:0] st, logic fnd, logic signed [31:0] val,
			logic lst);
		rsp_t r;
		r.status     = st;
		r.found      = fnd;
		r.out_value  = val;
		r.size_after = 7'(list_vals.size());
		r.last       = lst;
		expected_rsps.push_back(r);
	endfunction

	// Predict the results of one request and advance the model
	function automatic void predict_op(logic [3:0] kind, logic [6:0] position,
			logic signed [31:0] item_value);
		int n;
		bit hit;
		int tmp[$];
		n = list_vals.size();
		case (kind)
			K_INS_HEAD, K_INS_TAIL, K_INS_AT: begin
				if (kind == K_INS_AT && position > n)
					push_rsp(ST_INDEX, 0, 0, 1);
				else if (n >= POOL)
					push_rsp(ST_FULL, 0, 0, 1);
				else begin
					if (kind == K_INS_HEAD)
						list_vals.push_front(item_value);
					else if (kind == K_INS_TAIL)
						list_vals.push_back(item_value);
					else
						list_vals.insert(position, item_value);
					push_rsp(ST_OK, 0, 0, 1);
				end
			end
			K_DEL_HEAD, K_DEL_TAIL, K_DEL_AT: begin
				if (kind == K_DEL_AT && position >= n)
					push_rsp(ST_INDEX, 0, 0, 1);
				else if (n == 0)
					push_rsp(ST_EMPTY, 0, 0, 1);
				else begin
					if (kind == K_DEL_HEAD)
						void'(list_vals.pop_front());
					else if (kind == K_DEL_TAIL)
						void'(list_vals.pop_back());
					else
						list_vals.delete(position);
					push_rsp(ST_OK, 0, 0, 1);
				end
			end
			K_SEARCH: begin
				if (n == 0)
					push_rsp(ST_EMPTY, 0, 0, 1);
				else begin
					hit = 0;
					foreach (list_vals[i])
						if (list_vals[i] == item_value)
							hit = 1;
					push_rsp(ST_OK, hit, 0, 1);
				end
			end
			K_REVERSE: begin
				if (n == 0)
					push_rsp(ST_EMPTY, 0, 0, 1);
				else begin
					tmp = {};
					foreach (list_vals[i])
						tmp.push_front(list_vals[i]);
					list_vals = tmp;
					push_rsp(ST_OK, 0, 0, 1);
				end
			end
			K_DUMP_FWD, K_DUMP_BWD: begin
				if (n == 0)
					push_rsp(ST_EMPTY, 0, 0, 1);
				else
					for (int i = 0; i < n; i++)
						push_rsp(ST_OK, 0,
							list_vals[kind == K_DUMP_FWD ? i : n - 1 - i], i == n - 1);
			end
			default: push_rsp(ST_OK, 0, 0, 1);
		endcase
	endfunction
endpackage

>>> tb/testbench.sv
// Testbench top: drives requests into the list engine and checks every result.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cle_pkg::*;
	import cle_tb_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	bit   quiet = 0;
	bit   rx_hold = 0;
	int   idle_cycles = 0;
	int   rx_gap = 0;

	cle_req_if req ();
	cle_rsp_if rsp ();

	circular_list_engine dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	initial begin
		req.valid = 0;
		req.kind = 0;
		req.position = 0;
		req.item_value = 0;
		rsp.ready = 0;
		forever #5 clk = ~clk;
	end

	// Send one request, at times after a random gap (never when quiet); valid drops only in a gap
	task automatic send_req(logic [3:0] kind, logic [6:0] position, logic signed [31:0] val);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		req.valid <= 1;
		req.kind <= kind;
		req.position <= position;
		req.item_value <= val;
		do @(posedge clk); while (!req.ready);
		predict_op(kind, position, val);
		@(negedge clk);
	endtask

	// Drop valid and hold until every expected result has come
	task automatic wait_drained();
		req.valid <= 0;
		do @(negedge clk); while (expected_rsps.size() != 0);
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 3))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed($urandom_range(0, 7)) - 3;
			default: return $urandom;
		endcase
	endfunction

	// Receiver side: random stall bursts, or held off entirely while rx_hold is set
	always @(negedge clk) begin
		if (rx_hold)
			rsp.ready <= 0;
		else if (!quiet && rx_gap > 0) begin
			rsp.ready <= 0;
			rx_gap <= rx_gap - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rsp.ready <= 0;
			rx_gap <= $urandom_range(0, 16);
		end else
			rsp.ready <= 1;
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result");
				fail_count++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp.found);
					fail_count++;
				end
				if (rsp.out_value !== want.out_value) begin
					$error("out_value: expected %0d, got %0d", want.out_value, rsp.out_value);
					fail_count++;
				end
				if (rsp.size_after !== want.size_after) begin
					$error("size_after: expected %0d, got %0d", want.size_after,
						rsp.size_after);
					fail_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run after a long stretch with nothing accepted
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("[circular_list_engine] ERROR");
			$finish;
		end
	end

	// Empty list: every operation that needs an element, an out-of-range insert and an unknown kind
	task automatic test_empty_list();
		for (int k = K_DEL_HEAD; k <= K_DUMP_BWD; k++)
			send_req(k[3:0], 0, 0);
		send_req(K_INS_AT, 1, 5);
		send_req(4'd15, 0, 0);
	endtask

	// Directed inserts, deletes, search, reverse and dumps with extreme values, bad positions and an unknown kind
	task automatic test_basic_ops();
		send_req(K_INS_HEAD, 0, 32'sh8000_0000);
		send_req(K_INS_TAIL, 0, 32'sh7fff_ffff);
		send_req(K_INS_AT, 1, -1);
		send_req(K_INS_AT, 3, 0);
		send_req(K_INS_AT, 0, 1);
		send_req(K_INS_AT, 7'd64, 2);
		send_req(K_SEARCH, 0, -1);
		send_req(K_SEARCH, 0, 12345);
		send_req(K_DUMP_FWD, 0, 0);
		send_req(K_REVERSE, 0, 0);
		send_req(K_DUMP_BWD, 0, 0);
		send_req(K_DEL_AT, 2, 0);
		send_req(K_DEL_AT, 7'd127, 0);
		send_req(K_DEL_HEAD, 0, 0);
		send_req(K_DEL_TAIL, 0, 0);
		send_req(4'd10, 7'd85, 32'sh5555_5555);
		wait_drained();
	endtask

	// Fill the pool, overfill, dump full, then drain it to half
	task automatic test_full_pool();
		while (list_vals.size() < POOL)
			send_req(K_INS_AT, 7'($urandom_range(0, list_vals.size())), rand_val());
		send_req(K_INS_TAIL, 0, 7);
		send_req(K_INS_AT, 7'd64, 7);
		send_req(K_DUMP_FWD, 0, 0);
		send_req(K_DEL_AT, 7'd63, 0);
		while (list_vals.size() > POOL / 2)
			send_req(K_DEL_AT, 7'($urandom_range(0, list_vals.size() - 1)), 0);
		send_req(K_DUMP_BWD, 0, 0);
	endtask

	// Hold the receiver off while requests keep coming, then pause the sender
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1;
				repeat (300) @(negedge clk);
				rx_hold = 0;
			end
			for (int i = 0; i < 6; i++)
				send_req(i < 4 ? K_INS_TAIL : K_DUMP_FWD, 0, rand_val());
		join
		wait_drained();
	endtask

	// Random mix weighted toward inserts, with some unknown kinds and wild positions, later without idling
	task automatic test_random();
		int w;
		logic [3:0] k;
		logic [6:0] p;
		for (int i = 0; i < 50; i++) begin
			if (i == 35)
				quiet = 1;
			w = $urandom_range(0, 99);
			if (w < 30)
				k = 4'($urandom_range(K_INS_HEAD, K_INS_AT));
			else if (w < 50)
				k = 4'($urandom_range(K_DEL_HEAD, K_DEL_AT));
			else if (w < 65)
				k = K_SEARCH;
			else if (w < 72)
				k = K_REVERSE;
			else if (w < 80)
				k = 4'($urandom_range(K_DUMP_FWD, K_DUMP_BWD));
			else if (w < 83)
				k = 4'($urandom_range(10, 15));
			else
				k = K_INS_TAIL;
			if ($urandom_range(0, 9) == 0)
				p = 7'($urandom);
			else
				p = 7'($urandom_range(0, list_vals.size()));
			if (k == K_SEARCH && list_vals.size() > 0 && $urandom_range(0, 1))
				send_req(k, p, list_vals[$urandom_range(0, list_vals.size() - 1)]);
			else
				send_req(k, p, rand_val());
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		test_empty_list();
		test_basic_ops();
		test_full_pool();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (300) @(negedge clk);
		if (fail_count == 0 && expected_rsps.size() == 0)
			$display("[circular_list_engine] OK");
		else
			$display("[circular_list_engine] ERROR");
		$finish;
	end
endmodule
